// ===== src/grouped_min_max_sum_stats_top_assert.svh =====
// assertion macros for the grouped min/max/sum statistics block
`ifndef GROUPED_MIN_MAX_SUM_STATS_TOP_ASSERT_SVH
`define GROUPED_MIN_MAX_SUM_STATS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GMMS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GMMS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gmms_pkg.sv =====
// shared types and constants of the grouped min/max/sum statistics block
package gmms_pkg;

   // record and result field widths
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int TEMP_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 17;
   localparam int SUM_W     = 24;

   // capacity of the record store
   localparam int MAX_ITEMS = 65536;

   // month table geometry
   localparam int N_MONTHS    = 12;
   localparam int MONTH_IDX_W = $clog2(N_MONTHS);

   // valid field ranges
   localparam int TEMP_LO   = -99;
   localparam int TEMP_HI   = 99;
   localparam int MONTH_LO  = 1;
   localparam int MONTH_HI  = 12;
   localparam int DAY_LO    = 1;
   localparam int DAY_HI    = 31;
   localparam int HOUR_HI   = 23;
   localparam int MINUTE_HI = 59;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // one aggregate: count, sum, lowest and highest sample
   typedef struct packed {
      logic        [COUNT_W-1:0] count;
      logic signed [SUM_W-1:0]   sum;
      logic signed [TEMP_W-1:0]  lowest;
      logic signed [TEMP_W-1:0]  highest;
   } agg_type;

   localparam int AGG_W = $bits(agg_type);

endpackage

// ===== src/gmms_req_if.sv =====
// record channel: valid/ready handshake with the record fields
interface gmms_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [gmms_pkg::MONTH_W-1:0]  month;
   logic        [gmms_pkg::DAY_W-1:0]    day;
   logic        [gmms_pkg::HOUR_W-1:0]   hour;
   logic        [gmms_pkg::MINUTE_W-1:0] minute;
   logic signed [gmms_pkg::TEMP_W-1:0]   temperature;

   modport source (output valid, month, day, hour, minute, temperature, input ready);
   modport sink   (input valid, month, day, hour, minute, temperature, output ready);
endinterface

// ===== src/gmms_rsp_if.sv =====
// result channel: valid/ready handshake with status and aggregates
interface gmms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [gmms_pkg::STATUS_W-1:0] status;
   logic        [gmms_pkg::COUNT_W-1:0]  month_count;
   logic signed [gmms_pkg::SUM_W-1:0]    month_sum;
   logic signed [gmms_pkg::TEMP_W-1:0]   month_min;
   logic signed [gmms_pkg::TEMP_W-1:0]   month_max;
   logic        [gmms_pkg::COUNT_W-1:0]  year_count;
   logic signed [gmms_pkg::SUM_W-1:0]    year_sum;
   logic signed [gmms_pkg::TEMP_W-1:0]   year_min;
   logic signed [gmms_pkg::TEMP_W-1:0]   year_max;

   modport source (output valid, status, month_count, month_sum, month_min, month_max,
                   year_count, year_sum, year_min, year_max, input ready);
   modport sink   (input valid, status, month_count, month_sum, month_min, month_max,
                   year_count, year_sum, year_min, year_max, output ready);
endinterface

// ===== src/gmms_ram.sv =====
// generic single-port-write, registered-read RAM
module gmms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/gmms_agg_update.sv =====
// folds one temperature sample into a count/sum/min/max aggregate
module gmms_agg_update (
   input  gmms_pkg::agg_type                  cur_agg,
   input  logic signed [gmms_pkg::TEMP_W-1:0] temperature,
   output gmms_pkg::agg_type                  next_agg
);

   localparam int SUM_WIDE_W = gmms_pkg::SUM_W + 1;

   logic                           first_sample;
   logic signed [SUM_WIDE_W-1:0]   sum_wide;
   logic signed [gmms_pkg::TEMP_W-1:0] base_lowest;
   logic signed [gmms_pkg::TEMP_W-1:0] base_highest;

   // an empty aggregate takes the sample as its min and max
   assign first_sample = (cur_agg.count == '0);
   assign base_lowest  = first_sample ? temperature : cur_agg.lowest;
   assign base_highest = first_sample ? temperature : cur_agg.highest;

   // sum with one guard bit for saturation
   assign sum_wide = SUM_WIDE_W'(cur_agg.sum) + SUM_WIDE_W'(temperature);

   always_comb begin
      // count saturates at all ones
      next_agg.count = (&cur_agg.count) ? cur_agg.count
                                        : cur_agg.count + 1'b1;
      // clamp sum to the signed field range
      if (sum_wide[SUM_WIDE_W-1] != sum_wide[SUM_WIDE_W-2]) begin
         next_agg.sum = sum_wide[SUM_WIDE_W-1] ? {1'b1, {(gmms_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(gmms_pkg::SUM_W-1){1'b1}}};
      end else begin
         next_agg.sum = sum_wide[gmms_pkg::SUM_W-1:0];
      end
      next_agg.lowest  = (temperature < base_lowest)  ? temperature : base_lowest;
      next_agg.highest = (temperature > base_highest) ? temperature : base_highest;
   end

endmodule

// ===== src/grouped_min_max_sum_stats_top.sv =====
// top level: per-month and yearly temperature statistics over a month table
//
//  channel    dir   handshake      contents
//  req_chan   in    valid/ready    month, day, hour, minute, temperature
//  rsp_chan   out   valid/ready    status, month and year count/sum/min/max
//
// each transaction reads its month table entry from the registered-read RAM
// as the record is taken, then updates, writes back and loads the result
// register; a new record is taken only once the update stage finishes.
// reset clears the twelve entry valid bits and the yearly aggregate at once.
// a record is taken while a result waits; the update stage then holds until
// the result register drains.
module grouped_min_max_sum_stats_top (
   input logic       clock,
   input logic       reset,
   gmms_req_if.sink  req_chan,
   gmms_rsp_if.source rsp_chan
);

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type state_ff, state_in;

   // captured record
   logic        [gmms_pkg::MONTH_W-1:0]  month_ff;
   logic        [gmms_pkg::DAY_W-1:0]    day_ff;
   logic        [gmms_pkg::HOUR_W-1:0]   hour_ff;
   logic        [gmms_pkg::MINUTE_W-1:0] minute_ff;
   logic signed [gmms_pkg::TEMP_W-1:0]   temperature_ff;

   // table state
   logic [gmms_pkg::N_MONTHS-1:0] entry_valid_ff;
   gmms_pkg::agg_type             year_agg_ff;

   // result register
   logic                 rsp_valid_ff;
   gmms_pkg::status_type rsp_status_ff;
   gmms_pkg::agg_type    rsp_month_ff;
   gmms_pkg::agg_type    rsp_year_ff;

   logic [gmms_pkg::MONTH_IDX_W-1:0] req_idx;
   logic [gmms_pkg::MONTH_IDX_W-1:0] item_idx;
   logic [gmms_pkg::MONTH_IDX_W-1:0] rd_addr;
   logic [gmms_pkg::AGG_W-1:0]       rd_data;
   logic                             req_month_ok;
   logic                             month_ok;
   logic                             range_ok;
   logic                             store_full;
   logic                             load;
   logic                             commit;
   gmms_pkg::status_type             status;
   gmms_pkg::agg_type                cur_month;
   gmms_pkg::agg_type                next_month;
   gmms_pkg::agg_type                next_year;

   // month index, entry zero for an invalid month
   assign req_month_ok = (req_chan.month >= gmms_pkg::MONTH_W'(gmms_pkg::MONTH_LO)) &&
                         (req_chan.month <= gmms_pkg::MONTH_W'(gmms_pkg::MONTH_HI));
   assign req_idx      = req_month_ok ? gmms_pkg::MONTH_IDX_W'(req_chan.month - 1'b1) : '0;
   assign month_ok     = (month_ff >= gmms_pkg::MONTH_W'(gmms_pkg::MONTH_LO)) &&
                         (month_ff <= gmms_pkg::MONTH_W'(gmms_pkg::MONTH_HI));
   assign item_idx     = month_ok ? gmms_pkg::MONTH_IDX_W'(month_ff - 1'b1) : '0;

   // read the incoming record's entry at acceptance, then hold it
   assign rd_addr = (state_ff == ST_IDLE) ? req_idx : item_idx;

   gmms_ram #(
      .WIDTH (gmms_pkg::AGG_W),
      .DEPTH (gmms_pkg::N_MONTHS)
   ) u_month_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (item_idx),
      .wr_data (next_month),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an entry never written reads as zero
   assign cur_month = entry_valid_ff[item_idx] ? gmms_pkg::agg_type'(rd_data) : '0;

   // status decision
   assign store_full = (32'(year_agg_ff.count) >= 32'(gmms_pkg::MAX_ITEMS));
   assign range_ok   = (temperature_ff >= gmms_pkg::TEMP_W'(gmms_pkg::TEMP_LO)) &&
                       (temperature_ff <= gmms_pkg::TEMP_W'(gmms_pkg::TEMP_HI)) &&
                       month_ok &&
                       (day_ff >= gmms_pkg::DAY_W'(gmms_pkg::DAY_LO)) &&
                       (day_ff <= gmms_pkg::DAY_W'(gmms_pkg::DAY_HI)) &&
                       (hour_ff <= gmms_pkg::HOUR_W'(gmms_pkg::HOUR_HI)) &&
                       (minute_ff <= gmms_pkg::MINUTE_W'(gmms_pkg::MINUTE_HI));

   always_comb begin
      if (store_full) begin
         status = gmms_pkg::STATUS_FULL;
      end else if (!range_ok) begin
         status = gmms_pkg::STATUS_RANGE;
      end else begin
         status = gmms_pkg::STATUS_ACCEPTED;
      end
   end

   // month and year update
   gmms_agg_update u_month_upd (
      .cur_agg     (cur_month),
      .temperature (temperature_ff),
      .next_agg    (next_month)
   );

   gmms_agg_update u_year_upd (
      .cur_agg     (year_agg_ff),
      .temperature (temperature_ff),
      .next_agg    (next_year)
   );

   // update stage finishes once the result register is free
   assign load   = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_chan.ready);
   assign commit = load && (status == gmms_pkg::STATUS_ACCEPTED);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, table bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         year_agg_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            entry_valid_ff[item_idx] <= 1'b1;
            year_agg_ff              <= next_year;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         month_ff       <= req_chan.month;
         day_ff         <= req_chan.day;
         hour_ff        <= req_chan.hour;
         minute_ff      <= req_chan.minute;
         temperature_ff <= req_chan.temperature;
      end
      if (load) begin
         rsp_status_ff <= status;
         if (!month_ok) begin
            rsp_month_ff <= '0;
         end else if (status == gmms_pkg::STATUS_ACCEPTED) begin
            rsp_month_ff <= next_month;
         end else begin
            rsp_month_ff <= cur_month;
         end
         rsp_year_ff <= (status == gmms_pkg::STATUS_ACCEPTED) ? next_year : year_agg_ff;
      end
   end

   // result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.month_count = rsp_month_ff.count;
   assign rsp_chan.month_sum   = rsp_month_ff.sum;
   assign rsp_chan.month_min   = rsp_month_ff.lowest;
   assign rsp_chan.month_max   = rsp_month_ff.highest;
   assign rsp_chan.year_count  = rsp_year_ff.count;
   assign rsp_chan.year_sum    = rsp_year_ff.sum;
   assign rsp_chan.year_min    = rsp_year_ff.lowest;
   assign rsp_chan.year_max    = rsp_year_ff.highest;

   // checks
`include "grouped_min_max_sum_stats_top_assert.svh"

   `GMMS_ASSERT_IMP(a_no_take_in_calc, state_ff == ST_CALC, !req_chan.ready, "record taken during update")
   `GMMS_ASSERT_IMP(a_year_order, year_agg_ff.count != '0, year_agg_ff.lowest <= year_agg_ff.highest, "year min above max")
   `GMMS_ASSERT_NXT(a_reject_stable, load && !commit, $stable(year_agg_ff), "rejected record changed year")
   `GMMS_ASSERT_NXT(a_commit_count, commit && !(&year_agg_ff.count), year_agg_ff.count == $past(year_agg_ff.count) + 1'b1, "year count not advanced")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the grouped min/max/sum temperature statistics block
module testbench;

   localparam int COUNT_CEIL = 131071;
   localparam int SUM_CEIL   = 8388607;
   localparam int SUM_FLOOR  = -8388608;

   // one temperature record plus the idle cycles that follow it
   typedef struct {
      logic        [gmms_pkg::MONTH_W-1:0]  month;
      logic        [gmms_pkg::DAY_W-1:0]    day;
      logic        [gmms_pkg::HOUR_W-1:0]   hour;
      logic        [gmms_pkg::MINUTE_W-1:0] minute;
      logic signed [gmms_pkg::TEMP_W-1:0]   temperature;
      int unsigned                          idle;
   } reading_type;

   // status and aggregates reported for one record
   typedef struct packed {
      gmms_pkg::status_type status;
      gmms_pkg::agg_type    month_agg;
      gmms_pkg::agg_type    year_agg;
   } tally_type;

   logic clock;
   logic reset;

   gmms_req_if req_chan ();
   gmms_rsp_if rsp_chan ();

   grouped_min_max_sum_stats_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // pending records and expected tallies
   reading_type reading_q[$];
   tally_type   tally_q[$];
   int          readings_left = 0;

   // shadow month table and yearly aggregate
   gmms_pkg::agg_type month_table[gmms_pkg::N_MONTHS];
   gmms_pkg::agg_type year_table;

   reading_type cur_reading;
   bit          req_done = 0;
   int unsigned idle_left = 0;
   int unsigned stall_left = 0;
   bit          src_calm = 0;
   bit          sink_calm = 0;

   int n_accepted = 0;
   int n_range = 0;
   int n_full = 0;
   int n_checked = 0;
   int n_mismatch = 0;
   int n_orphan = 0;

   // clock
   always #1 clock = ~clock;

   // fold one sample into an aggregate; first sample seeds the extremes
   function automatic gmms_pkg::agg_type merge_sample(input gmms_pkg::agg_type a,
                                                      input int t);
      gmms_pkg::agg_type n;
      int                s;
      n = a;
      if (a.count == 0) begin
         n.lowest  = gmms_pkg::TEMP_W'(t);
         n.highest = gmms_pkg::TEMP_W'(t);
      end
      if (a.count < COUNT_CEIL) n.count = a.count + 1'b1;
      s = $signed(a.sum);
      s = s + t;
      if (s > SUM_CEIL) s = SUM_CEIL;
      if (s < SUM_FLOOR) s = SUM_FLOOR;
      n.sum = gmms_pkg::SUM_W'(s);
      if (t < $signed(n.lowest)) n.lowest = gmms_pkg::TEMP_W'(t);
      if (t > $signed(n.highest)) n.highest = gmms_pkg::TEMP_W'(t);
      return n;
   endfunction

   // update the shadow tables with one record and report the outcome
   function automatic tally_type apply_reading(input reading_type r);
      tally_type res;
      int        t;
      bit        month_ok;
      int        idx;
      t = r.temperature;
      month_ok = (r.month >= gmms_pkg::MONTH_LO) && (r.month <= gmms_pkg::MONTH_HI);
      idx = month_ok ? int'(r.month) - gmms_pkg::MONTH_LO : 0;
      if (int'(year_table.count) >= gmms_pkg::MAX_ITEMS) begin
         res.status = gmms_pkg::STATUS_FULL;
      end else if (t < gmms_pkg::TEMP_LO || t > gmms_pkg::TEMP_HI || !month_ok ||
                   r.day < gmms_pkg::DAY_LO || r.day > gmms_pkg::DAY_HI ||
                   r.hour > gmms_pkg::HOUR_HI || r.minute > gmms_pkg::MINUTE_HI) begin
         res.status = gmms_pkg::STATUS_RANGE;
      end else begin
         res.status = gmms_pkg::STATUS_ACCEPTED;
         month_table[idx] = merge_sample(month_table[idx], t);
         year_table = merge_sample(year_table, t);
      end
      res.month_agg = month_ok ? month_table[idx] : '0;
      res.year_agg  = year_table;
      return res;
   endfunction

   // idle length after a record: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned p;
      if (src_calm) return 0;
      p = $urandom_range(99, 0);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic reading_type pack_reading(input int m, input int d, input int h,
                                                input int mi, input int t);
      reading_type r;
      r.month       = gmms_pkg::MONTH_W'(m);
      r.day         = gmms_pkg::DAY_W'(d);
      r.hour        = gmms_pkg::HOUR_W'(h);
      r.minute      = gmms_pkg::MINUTE_W'(mi);
      r.temperature = gmms_pkg::TEMP_W'(t);
      r.idle        = pick_gap();
      return r;
   endfunction

   // mostly well-formed records, the rest with one field or all fields broken
   function automatic reading_type random_reading(input bit clean_only);
      reading_type r;
      int          t;
      if ($urandom_range(9, 0) == 0)
         t = $urandom_range(1, 0) ? gmms_pkg::TEMP_HI : gmms_pkg::TEMP_LO;
      else
         t = int'($urandom_range(198, 0)) - 99;
      r = pack_reading($urandom_range(gmms_pkg::MONTH_HI, gmms_pkg::MONTH_LO),
                       $urandom_range(gmms_pkg::DAY_HI, gmms_pkg::DAY_LO),
                       $urandom_range(gmms_pkg::HOUR_HI, 0),
                       $urandom_range(gmms_pkg::MINUTE_HI, 0), t);
      if (!clean_only && $urandom_range(99, 0) < 15) begin
         case ($urandom_range(5, 0))
            0: r.month = $urandom_range(1, 0) ? '0
                                              : gmms_pkg::MONTH_W'($urandom_range(15, 13));
            1: r.day = '0;
            2: r.hour = gmms_pkg::HOUR_W'($urandom_range(31, 24));
            3: r.minute = gmms_pkg::MINUTE_W'($urandom_range(63, 60));
            4: r.temperature = $urandom_range(1, 0)
                  ? gmms_pkg::TEMP_W'($urandom_range(127, 100))
                  : gmms_pkg::TEMP_W'(-int'($urandom_range(128, 100)));
            default: begin
               r.month       = gmms_pkg::MONTH_W'($urandom);
               r.day         = gmms_pkg::DAY_W'($urandom);
               r.hour        = gmms_pkg::HOUR_W'($urandom);
               r.minute      = gmms_pkg::MINUTE_W'($urandom);
               r.temperature = gmms_pkg::TEMP_W'($urandom);
            end
         endcase
      end
      return r;
   endfunction

   task automatic queue_reading(input reading_type r);
      reading_q.push_back(r);
      readings_left++;
   endtask

   // hold off until every queued record has been answered
   task automatic wait_drained();
      while (readings_left != 0 || tally_q.size() != 0) @(negedge clock);
   endtask

   // record acceptance: predict the result of each transaction
   always @(posedge clock) begin
      tally_type want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         want = apply_reading(cur_reading);
         tally_q.push_back(want);
         readings_left--;
         req_done = 1;
         case (want.status)
            gmms_pkg::STATUS_ACCEPTED: n_accepted++;
            gmms_pkg::STATUS_RANGE:    n_range++;
            default:                   n_full++;
         endcase
      end
   end

   // record driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_done) begin
         req_done = 0;
         if (idle_left != 0) begin
            idle_left--;
            req_chan.valid <= 1'b0;
         end else if (reading_q.size() != 0) begin
            cur_reading = reading_q.pop_front();
            idle_left = cur_reading.idle;
            req_chan.month       <= cur_reading.month;
            req_chan.day         <= cur_reading.day;
            req_chan.hour        <= cur_reading.hour;
            req_chan.minute      <= cur_reading.minute;
            req_chan.temperature <= cur_reading.temperature;
            req_chan.valid       <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(99, 0) < 30) begin
         stall_left = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3, 1);
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // result monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      tally_type got;
      tally_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status              = gmms_pkg::status_type'(rsp_chan.status);
         got.month_agg.count     = rsp_chan.month_count;
         got.month_agg.sum       = rsp_chan.month_sum;
         got.month_agg.lowest    = rsp_chan.month_min;
         got.month_agg.highest   = rsp_chan.month_max;
         got.year_agg.count      = rsp_chan.year_count;
         got.year_agg.sum        = rsp_chan.year_sum;
         got.year_agg.lowest     = rsp_chan.year_min;
         got.year_agg.highest    = rsp_chan.year_max;
         if (tally_q.size() == 0) begin
            n_orphan++;
            $display("%0t: result with nothing outstanding, status %0d", $realtime,
                     rsp_chan.status);
         end else begin
            want = tally_q.pop_front();
            n_checked++;
            if (got.status !== want.status ||
                got.month_agg.count !== want.month_agg.count ||
                got.month_agg.sum !== want.month_agg.sum ||
                got.month_agg.lowest !== want.month_agg.lowest ||
                got.month_agg.highest !== want.month_agg.highest ||
                got.year_agg.count !== want.year_agg.count ||
                got.year_agg.sum !== want.year_agg.sum ||
                got.year_agg.lowest !== want.year_agg.lowest ||
                got.year_agg.highest !== want.year_agg.highest) begin
               n_mismatch++;
               if (n_mismatch <= 10) begin
                  $display("%0t: result %0d differs", $realtime, n_checked);
                  $display("  exp st %0d month %0d/%0d/%0d/%0d year %0d/%0d/%0d/%0d",
                           want.status,
                           want.month_agg.count, want.month_agg.sum,
                           want.month_agg.lowest, want.month_agg.highest,
                           want.year_agg.count, want.year_agg.sum,
                           want.year_agg.lowest, want.year_agg.highest);
                  $display("  got st %0d month %0d/%0d/%0d/%0d year %0d/%0d/%0d/%0d",
                           got.status,
                           got.month_agg.count, got.month_agg.sum,
                           got.month_agg.lowest, got.month_agg.highest,
                           got.year_agg.count, got.year_agg.sum,
                           got.year_agg.lowest, got.year_agg.highest);
               end
            end
         end
      end
   end

   // run limit
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.month       = '0;
      req_chan.day         = '0;
      req_chan.hour        = '0;
      req_chan.minute      = '0;
      req_chan.temperature = '0;
      rsp_chan.ready       = 1'b0;
      year_table = '0;
      foreach (month_table[i]) month_table[i] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty tables, seeding, field extremes and each range check
      queue_reading(pack_reading(0, 15, 12, 30, 20));
      queue_reading(pack_reading(1, 1, 0, 0, -99));
      queue_reading(pack_reading(12, 31, 23, 59, 99));
      queue_reading(pack_reading(1, 31, 23, 59, 99));
      queue_reading(pack_reading(1, 1, 0, 0, 0));
      queue_reading(pack_reading(12, 1, 0, 0, -99));
      queue_reading(pack_reading(6, 10, 10, 10, 0));
      queue_reading(pack_reading(3, 5, 5, 5, 100));
      queue_reading(pack_reading(3, 5, 5, 5, -100));
      queue_reading(pack_reading(3, 5, 5, 5, 127));
      queue_reading(pack_reading(3, 5, 5, 5, -128));
      queue_reading(pack_reading(13, 5, 5, 5, 10));
      queue_reading(pack_reading(15, 31, 31, 63, -1));
      queue_reading(pack_reading(4, 0, 5, 5, 10));
      queue_reading(pack_reading(4, 5, 24, 5, 10));
      queue_reading(pack_reading(4, 5, 31, 5, 10));
      queue_reading(pack_reading(4, 5, 5, 60, 10));
      queue_reading(pack_reading(4, 5, 5, 63, 10));
      queue_reading(pack_reading(0, 0, 0, 0, 0));
      queue_reading(pack_reading(6, 20, 12, 30, -50));
      queue_reading(pack_reading(7, 1, 0, 0, -1));
      wait_drained();

      // random records in chunks, some chunks without any idling
      for (int c = 0; c < 23; c++) begin
         src_calm  = (c % 5 == 2);
         sink_calm = (c % 5 == 2);
         repeat (50) queue_reading(random_reading(1'b0));
         if (c == 11)
            wait_drained();
         else
            while (readings_left > 4) @(negedge clock);
      end
      src_calm  = 1'b0;
      sink_calm = 1'b0;
      wait_drained();

      // tail: invalid months and all-broken fields on loaded tables
      queue_reading(pack_reading(5, 5, 5, 5, 5));
      queue_reading(pack_reading(5, 5, 5, 5, 120));
      queue_reading(pack_reading(0, 5, 5, 5, 5));
      queue_reading(pack_reading(15, 31, 31, 63, -128));
      repeat (16) queue_reading(random_reading(1'b0));
      wait_drained();
      repeat (8) @(negedge clock);

      $display("covered %0d accepted, %0d out-of-range and %0d store-full records",
               n_accepted, n_range, n_full);
      $display("%0d results checked, %0d mismatched, %0d unexpected",
               n_checked, n_mismatch, n_orphan);
      if (n_mismatch == 0 && n_orphan == 0 && tally_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
